/* sv/sdssd_pkg.sv */
package sdssd_pkg;

	// number of digit slots in the chain
	localparam int DIGIT_COUNT = 6;
	// slots that appear on the matrix rows
	localparam int SHOWN = (DIGIT_COUNT < 6) ? DIGIT_COUNT : 6;
	// magnitude width: covers 999999
	localparam int MAG_W = 20;
	localparam int ROW_W = 6;
	localparam int IDX_W = 3;

	// divide by ten: q = (x * ceil(2^23/10)) >> 23, exact for x below 2^22
	localparam logic [MAG_W-1:0] RECIP_10 = 20'd838861;
	localparam int RECIP_SH = 23;

	localparam logic signed [31:0] PRINT_MIN = -32'sd99999;
	localparam logic signed [31:0] PRINT_MAX = 32'sd999999;

	localparam logic [7:0] GLYPH_MINUS = 8'h01;

	localparam logic [1:0] ACT_SET_ONE = 2'd0;
	localparam logic [1:0] ACT_SET_ALL = 2'd1;
	localparam logic [1:0] ACT_PRINT   = 2'd2;

	// direct slot write from the top level
	typedef struct packed {
		logic       en;
		logic [7:0] data;
	} wr_t;

	// conversion token handed from a cell to its left neighbor
	typedef struct packed {
		logic             active;
		logic             minus;
		logic             neg;
		logic [MAG_W-1:0] mag;
	} token_t;

	function automatic logic [7:0] glyph(input logic [3:0] d);
		logic [7:0] g;
		case (d)
			4'd0:    g = 8'h7E;
			4'd1:    g = 8'h30;
			4'd2:    g = 8'h6D;
			4'd3:    g = 8'h79;
			4'd4:    g = 8'h33;
			4'd5:    g = 8'h5B;
			4'd6:    g = 8'h5F;
			4'd7:    g = 8'h70;
			4'd8:    g = 8'h7F;
			4'd9:    g = 8'h7B;
			default: g = 8'h00;
		endcase
		return g;
	endfunction

endpackage

/* sv/sdssd_cell.sv */
module sdssd_cell import sdssd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  wr_t        wr,
	input  token_t     token_in,
	output token_t     token_out,
	output logic       token_active,
	output logic [7:0] seg
);

	token_t           token_q;
	logic [7:0]       seg_q;
	logic [2*MAG_W-1:0] prod;
	logic [MAG_W-1:0] quot;
	logic [MAG_W-1:0] quot_x10;
	logic [MAG_W-1:0] rem_full;
	logic [3:0]       rem;

	// one decimal digit off the magnitude
	always_comb begin
		prod     = token_q.mag * RECIP_10;
		quot     = MAG_W'(prod[2*MAG_W-1:RECIP_SH]);
		quot_x10 = (quot << 3) + (quot << 1);
		rem_full = token_q.mag - quot_x10;
		rem      = rem_full[3:0];
	end

	// next token: continue with the quotient, or place a minus, or stop
	always_comb begin
		token_out = '0;
		if (token_q.active && !token_q.minus) begin
			if (quot != '0) begin
				token_out.active = 1'b1;
				token_out.neg    = token_q.neg;
				token_out.mag    = quot;
			end else if (token_q.neg) begin
				token_out.active = 1'b1;
				token_out.minus  = 1'b1;
			end
		end
	end

	// token stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= '0;
		end else begin
			token_q <= token_in;
		end
	end

	// slot byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= '0;
		end else if (wr.en) begin
			seg_q <= wr.data;
		end else if (token_q.active) begin
			seg_q <= token_q.minus ? GLYPH_MINUS : glyph(rem);
		end
	end

	assign seg          = seg_q;
	assign token_active = token_q.active;

endmodule

/* sv/signed_decimal_seven_segment_display.sv */
// channel | signals                                   | accepted when
// input   | in_valid, in_ready, action .. number      | in_valid && in_ready
// output  | out_valid, out_ready, status, row_*       | out_valid && out_ready
//
// A set item writes its slot bytes when accepted and is then loaded into the
// output register; the next word can be taken only after that load. A print
// first waits while the digit token walks the cell chain right to left, one
// cell per decimal digit and one more for the minus sign.
// One item is in flight at a time; in_ready is low until its result is
// loaded into the output register, which waits while out_ready is low.
// Reset clears all slot bytes to zero and empties the chain.
module signed_decimal_seven_segment_display import sdssd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        action,
	input  logic [IDX_W-1:0]  digit_index,
	input  logic [7:0]        pattern_one,
	input  logic [7:0]        pattern_two,
	input  logic [7:0]        pattern_three,
	input  logic [7:0]        pattern_four,
	input  logic [7:0]        pattern_five,
	input  logic [7:0]        pattern_six,
	input  logic signed [31:0] number,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              status,
	output logic [ROW_W-1:0]  row_zero,
	output logic [ROW_W-1:0]  row_one,
	output logic [ROW_W-1:0]  row_three,
	output logic [ROW_W-1:0]  row_four,
	output logic [ROW_W-1:0]  row_five,
	output logic [ROW_W-1:0]  row_six,
	output logic [ROW_W-1:0]  row_seven
);

	logic                      accept;
	logic                      busy_q;
	logic                      status_pend_q;
	logic                      out_valid_q;
	logic                      status_q;
	logic [6:0][ROW_W-1:0]     rows_q;
	logic [6:0][ROW_W-1:0]     rows_w;
	logic [5:0][7:0]           patterns;
	logic                      out_range;
	logic                      is_print;
	logic signed [31:0]        neg_number;
	wr_t    [DIGIT_COUNT-1:0]  wr;
	token_t [DIGIT_COUNT:0]    chain;
	logic   [DIGIT_COUNT-1:0]  active;
	logic   [DIGIT_COUNT-1:0][7:0] seg;
	logic                      any_active;
	logic                      done;

	assign accept     = in_valid && in_ready;
	assign in_ready   = !busy_q;
	assign patterns   = {pattern_six, pattern_five, pattern_four,
	                     pattern_three, pattern_two, pattern_one};
	assign is_print   = (action == ACT_PRINT);
	assign out_range  = (number < PRINT_MIN) || (number > PRINT_MAX);
	assign neg_number = -number;

	// direct slot writes for the set actions
	always_comb begin
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			wr[i].en   = 1'b0;
			wr[i].data = '0;
			if (accept && action == ACT_SET_ONE && digit_index == IDX_W'(i)) begin
				wr[i].en   = 1'b1;
				wr[i].data = pattern_one;
			end
			if (accept && action == ACT_SET_ALL && i < 6) begin
				wr[i].en   = 1'b1;
				wr[i].data = patterns[i];
			end
		end
	end

	// token injected at the rightmost cell
	always_comb begin
		chain[DIGIT_COUNT] = '0;
		if (accept && is_print && !out_range) begin
			chain[DIGIT_COUNT].active = 1'b1;
			chain[DIGIT_COUNT].neg    = number[31];
			chain[DIGIT_COUNT].mag    = number[31] ? neg_number[MAG_W-1:0]
			                                       : number[MAG_W-1:0];
		end
	end

	// cell chain, slot i takes its token from slot i+1
	for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_cell
		sdssd_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.wr          (wr[i]),
			.token_in    (chain[i+1]),
			.token_out   (chain[i]),
			.token_active(active[i]),
			.seg         (seg[i])
		);
	end

	assign any_active = |active;
	assign done       = busy_q && !any_active && (!out_valid_q || out_ready);

	// segment bit 6 - r of slot i goes to row r bit i
	always_comb begin
		rows_w = '0;
		for (int r = 0; r < 7; r++) begin
			for (int i = 0; i < SHOWN; i++) begin
				rows_w[r][i] = seg[i][6-r];
			end
		end
	end

	// control and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			status_pend_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (accept) begin
				busy_q        <= 1'b1;
				status_pend_q <= is_print && out_range;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (done) begin
			status_q <= status_pend_q;
			rows_q   <= rows_w;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign row_zero  = rows_q[0];
	assign row_one   = rows_q[1];
	assign row_three = rows_q[2];
	assign row_four  = rows_q[3];
	assign row_five  = rows_q[4];
	assign row_six   = rows_q[5];
	assign row_seven = rows_q[6];

	// at most one conversion token walks the chain
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(active))
		else $error("more than one token in the cell chain");

	// no new word is taken while a token is still moving
	assert property (@(posedge clk) disable iff (!arst_n) any_active |-> !in_ready)
		else $error("input ready while conversion in progress");

	// an out of range print never starts a conversion
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_print && out_range |=> !any_active)
		else $error("token started for out of range number");

	// finished item with a free output slot shows up next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !any_active && !out_valid_q |=> out_valid_q)
		else $error("result word not delivered");

endmodule

/* tb/signed_decimal_seven_segment_display_tb.sv */
module signed_decimal_seven_segment_display_tb;
	import sdssd_pkg::*;

	// action code that the block leaves alone
	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam logic [7:0] GLYPH_ZERO = 8'h7E;
	localparam logic [7:0] DIGIT_GLYPH [10] = '{
		8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
	};
	localparam int USEFUL_WORDS = 1650;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_PRINTED = 50;

	typedef struct packed {
		logic [1:0]        action;
		logic [IDX_W-1:0]  index;
		logic [0:5][7:0]   pat;
		logic signed [31:0] number;
	} word_t;

	typedef struct packed {
		logic             status;
		logic [0:6][5:0]  rows;
	} display_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] action = '0;
	logic [IDX_W-1:0] digit_index = '0;
	logic [7:0] pattern_one = '0;
	logic [7:0] pattern_two = '0;
	logic [7:0] pattern_three = '0;
	logic [7:0] pattern_four = '0;
	logic [7:0] pattern_five = '0;
	logic [7:0] pattern_six = '0;
	logic signed [31:0] number = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic status;
	logic [ROW_W-1:0] row_zero, row_one, row_three, row_four, row_five, row_six, row_seven;

	word_t words_to_send [$];
	display_t displays_due [$];
	logic [7:0] slot_bytes [DIGIT_COUNT];
	string row_label [7] = '{"row_zero", "row_one", "row_three", "row_four",
		"row_five", "row_six", "row_seven"};

	int errors = 0;
	int cycles = 0;
	int words_accepted = 0;
	logic word_taken = 1'b0;
	logic hold_off = 1'b0;
	int burst_left = 1;
	int gap_left = 0;
	int stall_mode = 0;
	int stall_timer = 0;

	signed_decimal_seven_segment_display dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .digit_index(digit_index),
		.pattern_one(pattern_one), .pattern_two(pattern_two),
		.pattern_three(pattern_three), .pattern_four(pattern_four),
		.pattern_five(pattern_five), .pattern_six(pattern_six),
		.number(number),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status),
		.row_zero(row_zero), .row_one(row_one), .row_three(row_three),
		.row_four(row_four), .row_five(row_five), .row_six(row_six),
		.row_seven(row_seven)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (errors < MAX_PRINTED)
			$display("mismatch %s at cycle %0d: got %0h want %0h", what, cycles, got, want);
		errors++;
	endtask

	// update the slot copy with one word and queue the display it yields
	task automatic apply_word(input word_t w);
		display_t d;
		int mag;
		int slot;
		logic neg;
		d = '0;
		case (w.action)
			ACT_SET_ONE: begin
				if (w.index < DIGIT_COUNT)
					slot_bytes[w.index] = w.pat[0];
			end
			ACT_SET_ALL: begin
				for (int k = 0; k < SHOWN; k++)
					slot_bytes[k] = w.pat[k];
			end
			ACT_PRINT: begin
				if (w.number < PRINT_MIN || w.number > PRINT_MAX) begin
					d.status = 1'b1;
				end else if (w.number == 0) begin
					slot_bytes[DIGIT_COUNT-1] = GLYPH_ZERO;
				end else begin
					neg = w.number < 0;
					mag = neg ? -w.number : w.number;
					slot = DIGIT_COUNT - 1;
					// digits from the right, stop after the leading one
					forever begin
						slot_bytes[slot] = DIGIT_GLYPH[mag % 10];
						mag = mag / 10;
						if (mag == 0 || slot == 0)
							break;
						slot--;
					end
					if (neg && slot > 0)
						slot_bytes[slot-1] = GLYPH_MINUS;
				end
			end
			default: ;
		endcase
		// row r carries segment bit 6 - r, bit i is slot i
		for (int i = 0; i < SHOWN; i++)
			for (int r = 0; r < 7; r++)
				d.rows[r][i] = slot_bytes[i][6-r];
		displays_due.push_back(d);
	endtask

	function automatic word_t random_word();
		word_t w;
		w.action = 2'($urandom_range(0, 3));
		w.index = IDX_W'($urandom_range(0, 7));
		for (int k = 0; k < 6; k++)
			w.pat[k] = 8'($urandom_range(0, 255));
		w.number = $urandom;
		return w;
	endfunction

	// printable values of every length, boundaries, and wild 32-bit values
	function automatic logic signed [31:0] pick_number();
		int sel;
		int digits;
		int lo;
		int hi;
		int mag;
		logic signed [31:0] v;
		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			digits = $urandom_range(1, 6);
			if ($urandom_range(0, 1) && digits == 6)
				digits = 5;
			lo = 1;
			for (int k = 1; k < digits; k++)
				lo = lo * 10;
			hi = lo * 10 - 1;
			mag = $urandom_range(hi, lo);
			v = (digits < 6 && $urandom_range(0, 1)) ? -mag : mag;
		end else if (sel < 78) begin
			v = 0;
		end else if (sel < 90) begin
			case ($urandom_range(0, 13))
				0: v = -100000;
				1: v = -99999;
				2: v = -99998;
				3: v = 999998;
				4: v = 999999;
				5: v = 1000000;
				6: v = -1;
				7: v = 1;
				8: v = -10;
				9: v = 99999;
				10: v = 100000;
				11: v = 32'sh80000000;
				12: v = 32'sh7FFFFFFF;
				default: v = -9;
			endcase
		end else begin
			v = $urandom;
		end
		return v;
	endfunction

	task automatic queue_word(input logic [1:0] act, input int idx,
			input logic [47:0] pats, input logic signed [31:0] num);
		word_t w;
		w = random_word();
		w.action = act;
		w.index = IDX_W'(idx);
		w.pat = pats;
		w.number = num;
		words_to_send.push_back(w);
	endtask

	// stimulus, drain and verdict
	initial begin
		word_t w;
		int useful;
		int sel;
		queue_word(ACT_SET_ALL, 0, {6{8'hFF}}, 0);
		queue_word(ACT_SET_ALL, 0, {6{8'h00}}, 0);
		queue_word(ACT_SET_ALL, 0, 48'h0102_0408_1020, 0);
		queue_word(ACT_PRINT, 0, 48'h0, 0);
		queue_word(ACT_PRINT, 0, 48'h0, 999999);
		queue_word(ACT_PRINT, 0, 48'h0, 1000000);
		queue_word(ACT_PRINT, 0, 48'h0, -99999);
		queue_word(ACT_PRINT, 0, 48'h0, -100000);
		queue_word(ACT_SET_ALL, 0, 48'hA55A_A55A_A55A, 0);
		queue_word(ACT_PRINT, 0, 48'h0, 7);
		queue_word(ACT_PRINT, 0, 48'h0, -1);
		queue_word(ACT_PRINT, 0, 48'h0, 32'sh80000000);
		queue_word(ACT_PRINT, 0, 48'h0, 32'sh7FFFFFFF);
		for (int i = 0; i < 8; i++)
			queue_word(ACT_SET_ONE, i, {6{(i % 2) ? 8'hFF : 8'h80}}, 0);
		queue_word(ACT_NONE, 0, {6{8'hFF}}, 12345);
		queue_word(ACT_PRINT, 0, 48'h0, -42);
		queue_word(ACT_PRINT, 0, 48'h0, 123456);

		useful = 0;
		while (useful < USEFUL_WORDS) begin
			w = random_word();
			sel = $urandom_range(0, 99);
			if (sel < 50) begin
				w.action = ACT_PRINT;
				w.number = pick_number();
			end else if (sel < 72) begin
				w.action = ACT_SET_ONE;
			end else if (sel < 93) begin
				w.action = ACT_SET_ALL;
			end else begin
				w.action = ACT_NONE;
			end
			words_to_send.push_back(w);
			useful++;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (words_to_send.size() != 0 || in_valid || displays_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (displays_due.size() != 0)
			report_mismatch("displays left over", displays_due.size(), 0);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// reset starts with every slot cleared
	initial begin
		for (int i = 0; i < DIGIT_COUNT; i++)
			slot_bytes[i] = 8'h00;
	end

	// sender: bursts of words with random gaps
	always @(negedge clk) begin : drive_words
		word_t w;
		if (arst_n && (!in_valid || word_taken)) begin
			if (gap_left > 0 || words_to_send.size() == 0) begin
				if (gap_left > 0)
					gap_left = gap_left - 1;
				in_valid <= 1'b0;
			end else begin
				w = words_to_send.pop_front();
				action <= w.action;
				digit_index <= w.index;
				pattern_one <= w.pat[0];
				pattern_two <= w.pat[1];
				pattern_three <= w.pat[2];
				pattern_four <= w.pat[3];
				pattern_five <= w.pat[4];
				pattern_six <= w.pat[5];
				number <= w.number;
				in_valid <= 1'b1;
				burst_left = burst_left - 1;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 20);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
	end

	// receiver: stall pattern changes every so often
	always @(negedge clk) begin
		stall_timer = stall_timer + 1;
		if (stall_timer >= 150) begin
			stall_timer = 0;
			stall_mode = $urandom_range(0, 3);
		end
		if (hold_off)
			out_ready <= 1'b0;
		else case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 1) == 1);
			2: out_ready <= ($urandom_range(0, 4) == 0);
			default: out_ready <= (stall_timer % 7) >= 3;
		endcase
	end

	// one long hold-off so the block backs up and drops in_ready
	initial begin
		while (words_accepted < 400)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// check displays, predict accepted words
	always @(posedge clk) begin : check_display
		display_t got;
		display_t want;
		word_t w;
		if (arst_n && out_valid && out_ready) begin
			got.status = status;
			got.rows = {row_zero, row_one, row_three, row_four, row_five, row_six, row_seven};
			if (displays_due.size() == 0) begin
				report_mismatch("unexpected display word", 32'(got), 0);
			end else begin
				want = displays_due.pop_front();
				if (got.status !== want.status)
					report_mismatch("status", 32'(got.status), 32'(want.status));
				for (int r = 0; r < 7; r++)
					if (got.rows[r] !== want.rows[r])
						report_mismatch(row_label[r], 32'(got.rows[r]),
							32'(want.rows[r]));
			end
		end
		if (arst_n && in_valid && in_ready) begin
			w.action = action;
			w.index = digit_index;
			w.pat = {pattern_one, pattern_two, pattern_three, pattern_four,
				pattern_five, pattern_six};
			w.number = number;
			apply_word(w);
			words_accepted <= words_accepted + 1;
			word_taken <= 1'b1;
		end else begin
			word_taken <= 1'b0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

endmodule
